// ===== rtl/rpg_pkg.sv =====
// shared types, constants and character tables for the password generator
package rpg_pkg;

  localparam int MAX_LEN   = 32;
  localparam int SET_COUNT = 8;
  localparam int POS_W     = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_NOSET  = 2'd1;
  localparam logic [1:0] ERR_MINSUM = 2'd2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic [1:0] CFG_MASK = 2'd0;
  localparam logic [1:0] CFG_MINS = 2'd1;
  localparam logic [1:0] CFG_LEN  = 2'd2;

  typedef struct packed {
    logic       op;
    logic [7:0] rbyte;
  } item_t;

  function automatic logic [7:0] set_size(input logic [2:0] k);
    case (k)
      3'd0: set_size = 8'd26;
      3'd1: set_size = 8'd26;
      3'd2: set_size = 8'd10;
      3'd3: set_size = 8'd1;
      3'd4: set_size = 8'd1;
      3'd5: set_size = 8'd1;
      3'd6: set_size = 8'd22;
      default: set_size = 8'd8;
    endcase
  endfunction

  function automatic logic [6:0] set_char(input logic [2:0] k, input logic [4:0] r);
    logic [6:0] c;
    c = 7'd0;
    case (k)
      3'd0: c = 7'h41 + {2'b00, r};
      3'd1: c = 7'h61 + {2'b00, r};
      3'd2: c = 7'h30 + {2'b00, r};
      3'd3: c = 7'h2d;
      3'd4: c = 7'h5f;
      3'd5: c = 7'h20;
      3'd6: begin
        case (r)
          5'd0: c = 7'h22;  5'd1: c = 7'h23;  5'd2: c = 7'h24;  5'd3: c = 7'h25;
          5'd4: c = 7'h26;  5'd5: c = 7'h27;  5'd6: c = 7'h2a;  5'd7: c = 7'h2b;
          5'd8: c = 7'h2c;  5'd9: c = 7'h2e;  5'd10: c = 7'h2f; 5'd11: c = 7'h3a;
          5'd12: c = 7'h3b; 5'd13: c = 7'h3d; 5'd14: c = 7'h3f; 5'd15: c = 7'h21;
          5'd16: c = 7'h40; 5'd17: c = 7'h5c; 5'd18: c = 7'h5e; 5'd19: c = 7'h60;
          5'd20: c = 7'h7c; default: c = 7'h7e;
        endcase
      end
      default: begin
        case (r[2:0])
          3'd0: c = 7'h5b; 3'd1: c = 7'h5d; 3'd2: c = 7'h7b; 3'd3: c = 7'h7d;
          3'd4: c = 7'h28; 3'd5: c = 7'h29; 3'd6: c = 7'h3c; default: c = 7'h3e;
        endcase
      end
    endcase
    set_char = c;
  endfunction

endpackage

// ===== rtl/random_password_generator.sv =====
// top level of the random password generator
// random password generator: a start transaction (opcode 0) checks and latches the settings;
// bad settings give one result with character zero, last_char set and an error code. each
// random-byte transaction (opcode 1) then passes through three steps: latch the byte, form
// byte mod m for the current modulus two bits at a time, and test the byte and write the
// character ram. a byte is dropped unless its whole block of m values lies below 256, which
// is the same as byte < 256 - (256 mod m). after the minimum and fill draws, each accepted
// shuffle byte adds a ram swap (two reads, then two writes) before the next byte is taken.
// the password then comes out one character at a time (ram read, then the output register),
// last_char on the final one, and the receiver can stall it. a two-entry input queue keeps
// accepting transactions while it has room, also while the engine works or the output waits.
module random_password_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_character,
  output logic        out_last_char,
  output logic [1:0]  out_error_code
);
  rpg_pkg::item_t in_item, q_item;
  logic q_valid, q_pop;

  // pack the input transaction
  assign in_item.op    = in_opcode;
  assign in_item.rbyte = in_random_byte;

  rpg_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  rpg_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_character(out_character),
    .out_last_char(out_last_char), .out_error_code(out_error_code)
  );
endmodule

// ===== rtl/rpg_ram.sv =====
// generic ram with separate read and write ports and registered read
module rpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/rpg_front.sv =====
// input side: two-entry queue that accepts transactions independent of the engine while it has a free entry
module rpg_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rpg_pkg::item_t in_item,
  output logic          q_valid,
  output rpg_pkg::item_t q_item,
  input  logic          q_pop
);
  rpg_pkg::item_t buf_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = buf_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ (q_pop && q_valid);
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      buf_r[wr_r] <= in_item;
    end
  end
endmodule

// ===== rtl/rpg_back.sv =====
// engine: rejection sampling, fill, shuffle and password readout
module rpg_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [47:0]          cfg_wdata,
  input  logic                 q_valid,
  input  rpg_pkg::item_t       q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [6:0]           out_character,
  output logic                 out_last_char,
  output logic [1:0]           out_error_code
);
  localparam logic [2:0] S_IDLE = 3'd0, S_MIN = 3'd1, S_FILL = 3'd2, S_SHUF = 3'd3;
  localparam logic [2:0] S_SWAP = 3'd4, S_EMIT = 3'd5;
  localparam logic [2:0] ST_RD = 3'd0, ST_WA = 3'd1, ST_WB = 3'd2, ST_RB = 3'd3;
  localparam logic [2:0] ST_DIV = 3'd4;
  localparam int PW = rpg_pkg::POS_W;
  localparam int LW = rpg_pkg::LEN_W;

  logic [7:0]  mask_r;
  logic [47:0] mins_r;
  logic [5:0]  len_r;
  logic [7:0]  lk_mask_r;
  logic [47:0] lk_mins_r;
  logic [LW-1:0] lk_len_r;

  logic [2:0]  st_r;
  logic [2:0]  sub_r;
  logic [2:0]  cur_r;
  logic [5:0]  drawn_r;
  logic [LW-1:0] fill_r;
  logic [LW-1:0] shuf_r;
  logic [PW-1:0] swp_r;
  logic [6:0]  tmp_a_r, tmp_b_r;
  logic [LW-1:0] emit_r;
  logic [7:0]  usize_r;
  logic        emit_wait_r;

  // ram
  logic          we;
  logic [PW-1:0] waddr, raddr;
  logic [6:0]    wdata, rdata;
  rpg_ram #(.WIDTH(7), .DEPTH(rpg_pkg::MAX_LEN)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // settings check at start
  logic [LW-1:0] len_eff;
  logic [8:0]    min_sum;
  logic [7:0]    us;
  always_comb begin
    if (len_r == 6'd0) len_eff = LW'(1);
    else if ({1'b0, len_r} > 7'(rpg_pkg::MAX_LEN)) len_eff = LW'(rpg_pkg::MAX_LEN);
    else len_eff = LW'(len_r);
    min_sum = 9'd0;
    us = 8'd0;
    for (int k = 0; k < rpg_pkg::SET_COUNT; k++) begin
      if (mask_r[k]) min_sum = min_sum + {3'b000, mins_r[6*k +: 6]};
      if (mask_r[k]) us = us + rpg_pkg::set_size(3'(k));
    end
  end

  // modulus for the current step
  logic [7:0] m;
  logic [7:0] r;
  logic       okb;
  always_comb begin
    case (st_r)
      S_MIN:   m = rpg_pkg::set_size(cur_r);
      S_FILL:  m = usize_r;
      default: m = 8'(shuf_r) + 8'd1;
    endcase
  end

  // byte mod m, two quotient bits per cycle
  logic [7:0] div_r, rem_r;
  logic [1:0] dcnt_r;
  logic [7:0] rem_a, rem_b;
  always_comb begin
    rem_a = {rem_r[6:0], div_r[7]};
    if (rem_a >= m) rem_a = rem_a - m;
    rem_b = {rem_a[6:0], div_r[6]};
    if (rem_b >= m) rem_b = rem_b - m;
  end

  // byte kept when its block of m values fits entirely below 256
  assign r   = rem_r;
  assign okb = ({1'b0, q_item.rbyte} - {1'b0, rem_r} + {1'b0, m}) <= 9'd256;

  // union lookup: walk enabled sets
  logic [6:0] uchar;
  always_comb begin
    logic [7:0] rr;
    logic       done;
    rr = r;
    done = 1'b0;
    uchar = 7'd0;
    for (int k = 0; k < rpg_pkg::SET_COUNT; k++) begin
      if (!done && lk_mask_r[k]) begin
        if (rr < rpg_pkg::set_size(3'(k))) begin
          uchar = rpg_pkg::set_char(3'(k), rr[4:0]);
          done = 1'b1;
        end else begin
          rr = rr - rpg_pkg::set_size(3'(k));
        end
      end
    end
  end

  // next min step: first enabled set at or after a given one with a nonzero minimum
  function automatic logic [3:0] next_set(input logic [7:0] msk, input logic [47:0] mn,
                                          input logic [3:0] from);
    logic [3:0] res;
    res = 4'd8;
    for (int k = 7; k >= 0; k--) begin
      if (4'(k) >= from && msk[k] && mn[6*k +: 6] != 6'd0) res = 4'(k);
    end
    return res;
  endfunction

  logic is_start, is_byte;
  assign is_start = q_valid && q_item.op == rpg_pkg::OP_START;
  assign is_byte  = q_valid && q_item.op == rpg_pkg::OP_BYTE;

  logic err_pend_r;
  logic [1:0] err_code_r;
  logic [3:0] ns_start, ns_cur;
  assign ns_start = next_set(mask_r, mins_r, 4'd0);
  assign ns_cur   = next_set(lk_mask_r, lk_mins_r, {1'b0, cur_r} + 4'd1);

  always_comb begin
    we = 1'b0; waddr = fill_r[PW-1:0]; wdata = 7'd0;
    raddr = shuf_r[PW-1:0];
    q_pop = 1'b0;
    case (st_r)
      S_MIN: if (sub_r == ST_WA && is_byte && okb) begin
        we = 1'b1; wdata = rpg_pkg::set_char(cur_r, r[4:0]);
      end
      S_FILL: if (sub_r == ST_WA && is_byte && okb) begin
        we = 1'b1; wdata = uchar;
      end
      S_SWAP: begin
        if (sub_r == ST_RD) raddr = swp_r;
        if (sub_r == ST_WA) begin we = 1'b1; waddr = shuf_r[PW-1:0]; wdata = tmp_b_r; end
        if (sub_r == ST_WB) begin we = 1'b1; waddr = swp_r; wdata = tmp_a_r; end
      end
      S_EMIT: raddr = emit_r[PW-1:0];
      default: ;
    endcase
    if (st_r != S_SWAP && st_r != S_EMIT && !err_pend_r && q_valid) begin
      if (is_start || st_r == S_IDLE || sub_r == ST_WA) q_pop = 1'b1;
    end
  end

  // output register
  logic       ov_r;
  logic [6:0] oc_r;
  logic       ol_r;
  logic [1:0] oe_r;
  assign out_valid = ov_r;
  assign out_character = oc_r;
  assign out_last_char = ol_r;
  assign out_error_code = oe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 8'd0; mins_r <= 48'd0; len_r <= 6'd16;
      st_r <= S_IDLE; sub_r <= ST_RD; ov_r <= 1'b0; err_pend_r <= 1'b0;
      emit_wait_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rpg_pkg::CFG_MASK: mask_r <= cfg_wdata[7:0];
          rpg_pkg::CFG_MINS: mins_r <= cfg_wdata;
          rpg_pkg::CFG_LEN:  len_r  <= cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (err_pend_r && (!ov_r || out_ready)) begin
        ov_r <= 1'b1; oc_r <= 7'd0; ol_r <= 1'b1; oe_r <= err_code_r; err_pend_r <= 1'b0;
      end
      if (q_pop && is_start) begin
        sub_r <= ST_RD;
        if (mask_r == 8'd0) begin
          err_pend_r <= 1'b1; err_code_r <= rpg_pkg::ERR_NOSET; st_r <= S_IDLE;
        end else if (min_sum > 9'(len_eff)) begin
          err_pend_r <= 1'b1; err_code_r <= rpg_pkg::ERR_MINSUM; st_r <= S_IDLE;
        end else begin
          lk_mask_r <= mask_r; lk_mins_r <= mins_r; lk_len_r <= len_eff;
          usize_r <= us; fill_r <= '0; drawn_r <= 6'd0;
          if (ns_start[3]) st_r <= S_FILL;
          else begin st_r <= S_MIN; cur_r <= ns_start[2:0]; end
        end
      end else begin
        case (st_r)
          S_MIN, S_FILL, S_SHUF: begin
            if (sub_r == ST_RD) begin
              if (is_byte) begin
                rem_r <= 8'd0; div_r <= q_item.rbyte; dcnt_r <= 2'd0; sub_r <= ST_DIV;
              end
            end else if (sub_r == ST_DIV) begin
              rem_r <= rem_b;
              div_r <= {div_r[5:0], 2'b00};
              dcnt_r <= dcnt_r + 2'd1;
              if (dcnt_r == 2'd3) sub_r <= ST_WA;
            end else if (is_byte) begin
              sub_r <= ST_RD;
              if (okb) begin
                if (st_r == S_MIN) begin
                  fill_r <= fill_r + LW'(1);
                  if (drawn_r + 6'd1 < lk_mins_r[6*cur_r +: 6]) drawn_r <= drawn_r + 6'd1;
                  else begin
                    drawn_r <= 6'd0;
                    if (!ns_cur[3]) cur_r <= ns_cur[2:0];
                    else if (fill_r + LW'(1) < lk_len_r) st_r <= S_FILL;
                    else if (lk_len_r == LW'(1)) begin st_r <= S_EMIT; emit_r <= '0; end
                    else begin st_r <= S_SHUF; shuf_r <= lk_len_r - LW'(1); end
                  end
                end else if (st_r == S_FILL) begin
                  fill_r <= fill_r + LW'(1);
                  if (fill_r + LW'(1) >= lk_len_r) begin
                    if (lk_len_r == LW'(1)) begin st_r <= S_EMIT; emit_r <= '0; end
                    else begin st_r <= S_SHUF; shuf_r <= lk_len_r - LW'(1); end
                  end
                end else begin
                  swp_r <= r[PW-1:0]; st_r <= S_SWAP; sub_r <= ST_RD;
                end
              end
            end
          end
          S_SWAP: begin
            // ram read of shuf_r was issued in previous state; capture a then b
            case (sub_r)
              ST_RD: begin tmp_a_r <= rdata; sub_r <= ST_RB; end
              ST_RB: begin tmp_b_r <= rdata; sub_r <= ST_WA; end
              ST_WA: sub_r <= ST_WB;
              default: begin
                sub_r <= ST_RD;
                if (shuf_r == LW'(1)) begin st_r <= S_EMIT; emit_r <= '0; end
                else begin st_r <= S_SHUF; shuf_r <= shuf_r - LW'(1); end
              end
            endcase
          end
          S_EMIT: begin
            // wait for the registered ram read, then present when output slot is free
            if (!emit_wait_r) emit_wait_r <= 1'b1;
            else if (!ov_r || out_ready) begin
              ov_r <= 1'b1; oc_r <= rdata; oe_r <= rpg_pkg::ERR_OK;
              ol_r <= (emit_r + LW'(1) == lk_len_r);
              emit_wait_r <= 1'b0;
              if (emit_r + LW'(1) == lk_len_r) st_r <= S_IDLE;
              else emit_r <= emit_r + LW'(1);
            end
          end
          default: sub_r <= ST_RD;
        endcase
      end
    end
  end
endmodule

// ===== rtl/rpg_checker.sv =====
// port-level checker for the password generator, bound to the top level
module rpg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_character,
  input logic       out_last_char,
  input logic [1:0] out_error_code
);
  // error results are always single, zero-character, final
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != rpg_pkg::ERR_OK |-> out_last_char && out_character == 7'd0)
    else $error("error result not final or nonzero");
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code <= rpg_pkg::ERR_MINSUM)
    else $error("bad error code");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character))
    else $error("stalled result changed");
endmodule

bind random_password_generator rpg_checker u_chk (.*);

// ===== tb/sv/random_password_generator_tb.sv =====
// self-checking testbench for the random password generator
module random_password_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {GEN_IDLE, GEN_MIN, GEN_FILL, GEN_SHUF} gen_phase_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last_char;
    logic [1:0] error_code;
  } pw_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = rpg_pkg::CFG_MASK;
  logic [47:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = rpg_pkg::OP_START;
  logic [7:0]  in_random_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_character;
  logic        out_last_char;
  logic [1:0]  out_error_code;

  random_password_generator i_dut (.*);

  always #10 clk = ~clk;

  // character sets in set order
  string charset [8] = '{"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz",
                         "0123456789", "-", "_", " ", "\"#$%&'*+,./:;=?!@\\^`|~",
                         "[]{}()<>"};

  // register copies as written
  logic [7:0]  reg_mask = '0;
  logic [47:0] reg_mins = '0;
  logic [5:0]  reg_len  = 6'd16;

  // generator state, settings latched at start
  gen_phase_t  gen_phase = GEN_IDLE;
  logic [7:0]  run_mask = '0;
  logic [47:0] run_mins = '0;
  int          run_len = 16;
  int          cur_set, drawn, fill_pos, shuf_idx;
  logic [6:0]  pw_buf [rpg_pkg::MAX_LEN];

  rpg_pkg::item_t pending_items [$];
  pw_char_t       expected_chars [$];
  int       errs = 0;
  logic     no_idle = 1'b0;   // stretch with no idling on either side
  logic     hold_out = 1'b0;  // long receiver hold-off

  function automatic int min_cnt(input int k);
    return int'((run_mins >> (6 * k)) & 48'd63);
  endfunction

  function automatic bit set_on(input int k);
    return run_mask[k];
  endfunction

  function automatic int union_total();
    int t;
    t = 0;
    for (int k = 0; k < rpg_pkg::SET_COUNT; k++) if (set_on(k)) t += charset[k].len();
    return t;
  endfunction

  function automatic logic [6:0] union_pick(input int r);
    for (int k = 0; k < rpg_pkg::SET_COUNT; k++) begin
      if (set_on(k)) begin
        if (r < charset[k].len()) return 7'(charset[k][r]);
        r -= charset[k].len();
      end
    end
    return '0;
  endfunction

  function automatic void put_char(input logic [6:0] c);
    if (fill_pos < run_len) pw_buf[fill_pos] = c;
    fill_pos++;
  endfunction

  // step to the next point that needs a byte; 1 when the password is complete
  function automatic bit next_step();
    if (gen_phase == GEN_MIN) begin
      while (cur_set < rpg_pkg::SET_COUNT) begin
        if (set_on(cur_set) && drawn < min_cnt(cur_set)) return 1'b0;
        cur_set++;
        drawn = 0;
      end
      gen_phase = GEN_FILL;
    end
    if (gen_phase == GEN_FILL) begin
      if (fill_pos < run_len) return 1'b0;
      gen_phase = GEN_SHUF;
      shuf_idx = run_len - 1;
    end
    if (gen_phase == GEN_SHUF) begin
      if (shuf_idx > 0) return 1'b0;
      gen_phase = GEN_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // work out the characters that one accepted transaction produces
  function automatic void predict_password(input rpg_pkg::item_t it);
    int len, sum, m, r;
    logic [6:0] t;
    if (it.op == rpg_pkg::OP_START) begin
      len = (reg_len == 0) ? 1 :
            ((reg_len > rpg_pkg::MAX_LEN) ? rpg_pkg::MAX_LEN : int'(reg_len));
      gen_phase = GEN_IDLE;
      if (reg_mask == 0) begin
        expected_chars.push_back('{7'd0, 1'b1, rpg_pkg::ERR_NOSET});
        return;
      end
      sum = 0;
      for (int k = 0; k < rpg_pkg::SET_COUNT; k++)
        if (reg_mask[k]) sum += int'((reg_mins >> (6 * k)) & 48'd63);
      if (sum > len) begin
        expected_chars.push_back('{7'd0, 1'b1, rpg_pkg::ERR_MINSUM});
        return;
      end
      run_mask = reg_mask;
      run_mins = reg_mins;
      run_len = len;
      cur_set = 0; drawn = 0; fill_pos = 0; shuf_idx = 0;
      gen_phase = GEN_MIN;
      void'(next_step());
      return;
    end
    if (gen_phase == GEN_IDLE) return;
    case (gen_phase)
      GEN_MIN:  m = charset[cur_set].len();
      GEN_FILL: m = union_total();
      default:  m = shuf_idx + 1;
    endcase
    if (int'(it.rbyte) >= 256 - (256 % m)) return;  // rejected, no change
    r = int'(it.rbyte) % m;
    case (gen_phase)
      GEN_MIN: begin
        put_char(7'(charset[cur_set][r]));
        drawn++;
      end
      GEN_FILL: put_char(union_pick(r));
      default: begin
        t = pw_buf[shuf_idx];
        pw_buf[shuf_idx] = pw_buf[r];
        pw_buf[r] = t;
        shuf_idx--;
      end
    endcase
    if (!next_step()) return;
    for (int k = 0; k < run_len; k++)
      expected_chars.push_back('{pw_buf[k], k == run_len - 1, rpg_pkg::ERR_OK});
  endfunction

  // driver: offers queued transactions with random gaps
  int             in_gap = 0;
  rpg_pkg::item_t cur_item;
  always @(posedge clk) begin
    logic nv;
    nv = in_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_password(cur_item);
        nv = 1'b0;
        in_gap = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (!nv) begin
        if (in_gap > 0) in_gap--;
        else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          nv = 1'b1;
        end
      end
    end
    in_valid <= nv;
    in_opcode <= cur_item.op;
    in_random_byte <= cur_item.rbyte;
  end

  // monitor: checks each result transaction and stalls at random
  int out_stall = 0;
  always @(posedge clk) begin
    pw_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result: character %0h last_char %0b error_code %0d",
               out_character, out_last_char, out_error_code);
        errs++;
      end else begin
        want = expected_chars.pop_front();
        if (out_character !== want.character) begin
          $error("character expected %0h actual %0h", want.character, out_character);
          errs++;
        end
        if (out_last_char !== want.last_char) begin
          $error("last_char expected %0b actual %0b", want.last_char, out_last_char);
          errs++;
        end
        if (out_error_code !== want.error_code) begin
          $error("error_code expected %0d actual %0d", want.error_code, out_error_code);
          errs++;
        end
      end
      out_stall = no_idle ? 0 : $urandom_range(0, 15);
    end
    if (!rst_n || hold_out) out_ready <= 1'b0;
    else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      rpg_pkg::CFG_MASK: reg_mask = val[7:0];
      rpg_pkg::CFG_MINS: reg_mins = val;
      default:           reg_len = val[5:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input logic [7:0] mask, input logic [47:0] mins, input int len);
    cfg_write(rpg_pkg::CFG_MASK, {40'd0, mask});
    cfg_write(rpg_pkg::CFG_MINS, mins);
    cfg_write(rpg_pkg::CFG_LEN, {42'd0, len[5:0]});
  endtask

  // sender pauses here until everything expected has come back
  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid && expected_chars.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic push_item(input logic op, input logic [7:0] b);
    rpg_pkg::item_t it;
    it.op = op;
    it.rbyte = b;
    pending_items.push_back(it);
  endtask

  // one start followed by 2 * len + 2 random bytes, with the odd restart among them
  task automatic push_password(input int len);
    push_item(rpg_pkg::OP_START, 8'($urandom));
    for (int i = 0; i < 2 * len + 2; i++) begin
      if ($urandom_range(0, 60) == 0) push_item(rpg_pkg::OP_START, 8'($urandom));  // restart
      else push_item(rpg_pkg::OP_BYTE, 8'($urandom));
    end
  endtask

  initial begin
    logic [7:0]  mask;
    logic [47:0] mins;
    int          len;
    cur_item = '{rpg_pkg::OP_START, 8'd0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no set enabled, stray byte while idle is dropped
    push_item(rpg_pkg::OP_BYTE, 8'hff);
    push_item(rpg_pkg::OP_START, 8'h00);
    drain();

    // minimum counts over the length
    set_all(8'hff, {48{1'b1}}, 16);
    push_item(rpg_pkg::OP_START, 8'hff);
    drain();

    // length 0 taken as 1, disabled set minimum ignored, rejected top byte
    set_all(8'h01, {36'd0, 6'd63, 6'd1}, 0);
    push_item(rpg_pkg::OP_START, 8'h5a);
    push_item(rpg_pkg::OP_BYTE, 8'hff);
    push_item(rpg_pkg::OP_BYTE, 8'h00);
    drain();

    // single-character sets, every byte of a minimum draw accepted
    set_all(8'h38, {18'd0, 6'd1, 6'd1, 6'd1, 18'd0}, 4);
    push_item(rpg_pkg::OP_START, 8'h00);
    push_item(rpg_pkg::OP_START, 8'hff);  // restart while busy
    for (int i = 0; i < 8; i++) push_item(rpg_pkg::OP_BYTE, (i % 2) ? 8'hff : 8'h00);
    drain();

    // length above the maximum clamps to 32, receiver holds off so the block fills
    set_all(8'hff, 48'd0, 63);
    fork
      begin
        hold_out <= 1'b1;
        repeat (600) @(posedge clk);
        hold_out <= 1'b0;
      end
    join_none
    push_password(32);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      mask = 8'($urandom);
      if (mask == 0 && $urandom_range(0, 1)) mask = 8'h01;
      mins = '0;
      for (int k = 0; k < rpg_pkg::SET_COUNT; k++) mins[6 * k +: 6] = 6'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) mins = 48'({$urandom, $urandom});
      len = $urandom_range(1, 8);
      set_all(mask, mins, len);
      push_password(len);
      drain();
    end
    no_idle = 1'b0;

    if (expected_chars.size() != 0) errs++;
    if (errs == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
